// ===== rtl/core/bhs_pkg.sv =====
// ----------------------------------------------------------------------------
// bhs_pkg: shared types and constants of the bucketed hash set
// Request and result transaction types, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package bhs_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned ReqTypeW    = 2;
  localparam int unsigned KeyW        = 48;
  localparam int unsigned CharW       = 8;
  localparam int unsigned MaxKeyChars = KeyW / CharW;
  localparam int unsigned BucketOutW  = 2;

  // Parameter defaults
  localparam int unsigned BucketsDefault  = 4;
  localparam int unsigned KeyCharsDefault = 6;
  localparam int unsigned WaysDefault     = 8;

  // Depth of the queues between the parts
  localparam int unsigned QueueDepth = 2;

  // Request codes; code three is handled as a query
  typedef enum logic [ReqTypeW-1:0] {
    ReqInsert = 2'd0,
    ReqDelete = 2'd1,
    ReqQuery  = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [KeyW-1:0]     key;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic                  refused_full;
    logic [BucketOutW-1:0] bucket_index;
  } rsp_t;

  // Characters of the key that take part in hashing and compare
  function automatic int unsigned chars_used(input int unsigned key_chars);
    chars_used = (key_chars < MaxKeyChars) ? key_chars : MaxKeyChars;
  endfunction

endpackage

// ===== rtl/core/bhs_fifo.sv =====
// ----------------------------------------------------------------------------
// bhs_fifo: small register queue
// Decouples producer and consumer; full and empty are registered state only.
// ----------------------------------------------------------------------------
module bhs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer and count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/bhs_front.sv =====
// ----------------------------------------------------------------------------
// bhs_front: request intake and classification
// Trims the key at its first zero character, sums the characters, reduces
// the sum modulo the bucket count and queues the command for the back end.
// ----------------------------------------------------------------------------
module bhs_front #(
  parameter int unsigned Buckets  = bhs_pkg::BucketsDefault,
  parameter int unsigned KeyChars = bhs_pkg::KeyCharsDefault,
  localparam int unsigned CanonW  = bhs_pkg::CharW * bhs_pkg::chars_used(KeyChars),
  localparam int unsigned BktW    = $clog2(Buckets)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  bhs_pkg::req_t       req_i,
  output logic                req_full_o,
  input  logic                cmd_pop_i,
  output logic                cmd_empty_o,
  output bhs_pkg::req_type_e  cmd_op_o,
  output logic [CanonW-1:0]   cmd_key_o,
  output logic [BktW-1:0]     cmd_bucket_o
);

  localparam int unsigned Chars    = bhs_pkg::chars_used(KeyChars);
  localparam int unsigned SumW     = $clog2(Chars * 255 + 1);
  localparam int unsigned RecShift = SumW + 1;
  localparam int unsigned Recip    = (1 << RecShift) / Buckets;
  localparam int unsigned RecipW   = RecShift + 1;
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam int unsigned MulW     = SumW + 9;
  localparam int unsigned CmdW     = bhs_pkg::ReqTypeW + CanonW + BktW;

  logic [bhs_pkg::CharW-1:0]     ch;
  logic                          live;
  logic [CanonW-1:0]             canon;
  logic [SumW-1:0]               sum;
  logic [ProdW-1:0]              prod;
  logic [ProdW-RecShift-1:0]     quo_full;
  bhs_pkg::req_type_e            op;

  logic                          s1_valid_q, s1_valid_d;
  bhs_pkg::req_type_e            s1_op_q;
  logic [CanonW-1:0]             s1_key_q;
  logic [SumW-1:0]               s1_sum_q;
  logic [SumW-1:0]               s1_quo_q;

  logic [MulW-1:0]               qb, rem_raw, rem;
  logic [BktW-1:0]               bucket;
  logic                          cmd_full, s1_ready, accept, cmd_push;
  logic [CmdW-1:0]               cmd_wdata, cmd_rdata;

  // Key trim and character sum
  always_comb begin
    ch    = '0;
    live  = 1'b1;
    canon = '0;
    sum   = '0;
    for (int unsigned i = 0; i < Chars; i++) begin
      ch   = req_i.key[bhs_pkg::CharW*i +: bhs_pkg::CharW];
      live = live & (ch != '0);
      if (live) begin
        canon[bhs_pkg::CharW*i +: bhs_pkg::CharW] = ch;
        sum = sum + SumW'(ch);
      end
    end
  end

  // Quotient estimate by reciprocal; low by at most one
  assign prod     = ProdW'(sum) * ProdW'(Recip);
  assign quo_full = prod[ProdW-1:RecShift];

  // Request decode
  always_comb begin
    unique case (req_i.req_type)
      bhs_pkg::ReqInsert: op = bhs_pkg::ReqInsert;
      bhs_pkg::ReqDelete: op = bhs_pkg::ReqDelete;
      default:            op = bhs_pkg::ReqQuery;
    endcase
  end

  // Stage one handshake
  assign s1_ready   = ~s1_valid_q | ~cmd_full;
  assign req_full_o = ~s1_ready;
  assign accept     = req_valid_i & s1_ready;
  assign cmd_push   = s1_valid_q & ~cmd_full;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (cmd_push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= op;
      s1_key_q <= canon;
      s1_sum_q <= sum;
      s1_quo_q <= quo_full[SumW-1:0];
    end
  end

  // Remainder with a single correction step
  always_comb begin
    qb      = MulW'(s1_quo_q) * MulW'(Buckets);
    rem_raw = MulW'(s1_sum_q) - qb;
    rem     = (rem_raw >= MulW'(Buckets)) ? rem_raw - MulW'(Buckets) : rem_raw;
    bucket  = rem[BktW-1:0];
  end

  // Command queue to the back end
  assign cmd_wdata = {s1_op_q, s1_key_q, bucket};

  bhs_fifo #(
    .Width (CmdW),
    .Depth (bhs_pkg::QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty_o)
  );

  assign cmd_op_o     = bhs_pkg::req_type_e'(cmd_rdata[CmdW-1 -: bhs_pkg::ReqTypeW]);
  assign cmd_key_o    = cmd_rdata[BktW +: CanonW];
  assign cmd_bucket_o = cmd_rdata[BktW-1:0];

endmodule

// ===== rtl/core/bhs_back.sv =====
// ----------------------------------------------------------------------------
// bhs_back: bucket lookup and update
// Reads one bucket row, compares all ways in parallel, updates the row and
// produces the result transaction.
// ----------------------------------------------------------------------------
module bhs_back #(
  parameter int unsigned Buckets  = bhs_pkg::BucketsDefault,
  parameter int unsigned Ways     = bhs_pkg::WaysDefault,
  parameter int unsigned KeyChars = bhs_pkg::KeyCharsDefault,
  localparam int unsigned CanonW  = bhs_pkg::CharW * bhs_pkg::chars_used(KeyChars),
  localparam int unsigned BktW    = $clog2(Buckets)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  bhs_pkg::req_type_e cmd_op_i,
  input  logic [CanonW-1:0]  cmd_key_i,
  input  logic [BktW-1:0]    cmd_bucket_i,
  input  logic               rsp_full_i,
  output logic               rsp_push_o,
  output bhs_pkg::rsp_t      rsp_o
);

  typedef enum logic {
    BkIdle,
    BkEval
  } bk_state_e;

  bk_state_e          state_q;
  bhs_pkg::req_type_e cur_op_q;
  logic [CanonW-1:0]  cur_key_q;
  logic [BktW-1:0]    cur_bucket_q;

  // Bucket rows: keys and valid bits; a row not yet written reads as empty
  logic [CanonW-1:0]  key_mem [Buckets][Ways];
  logic [Ways-1:0]    valid_mem [Buckets];
  logic [Buckets-1:0] row_live_q;

  logic [CanonW-1:0]  row_keys_q [Ways];
  logic [Ways-1:0]    row_valid_q;
  logic               row_live_rd_q;

  logic [Ways-1:0]    valid_eff, match, hit_oh, free, free_oh;
  logic [Ways-1:0]    ins_oh, del_oh, valid_new;
  logic               hit, room, is_insert, is_delete;

  assign cmd_pop_o  = (state_q == BkIdle) & ~cmd_empty_i & ~rsp_full_i;
  assign rsp_push_o = (state_q == BkEval);

  // Sequencer and current command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BkIdle;
      cur_op_q     <= bhs_pkg::ReqQuery;
      cur_key_q    <= '0;
      cur_bucket_q <= '0;
    end else begin
      unique case (state_q)
        BkIdle: begin
          if (cmd_pop_o) begin
            state_q      <= BkEval;
            cur_op_q     <= cmd_op_i;
            cur_key_q    <= cmd_key_i;
            cur_bucket_q <= cmd_bucket_i;
          end
        end
        BkEval: begin
          state_q <= BkIdle;
        end
        default: begin
          state_q <= BkIdle;
        end
      endcase
    end
  end

  // Row-written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_live_q <= '0;
    end else if (state_q == BkEval) begin
      row_live_q[cur_bucket_q] <= 1'b1;
    end
  end

  // Row read on command pop, write-back at evaluation
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      row_keys_q    <= key_mem[cmd_bucket_i];
      row_valid_q   <= valid_mem[cmd_bucket_i];
      row_live_rd_q <= row_live_q[cmd_bucket_i];
    end
    if (state_q == BkEval) begin
      valid_mem[cur_bucket_q] <= valid_new;
      for (int unsigned w = 0; w < Ways; w++) begin
        if (ins_oh[w]) begin
          key_mem[cur_bucket_q][w] <= cur_key_q;
        end
      end
    end
  end

  // Parallel compare and slot selection
  always_comb begin
    valid_eff = row_live_rd_q ? row_valid_q : '0;
    for (int unsigned w = 0; w < Ways; w++) begin
      match[w] = valid_eff[w] & (row_keys_q[w] == cur_key_q);
    end
    hit_oh    = match & (~match + 1'b1);
    free      = ~valid_eff;
    free_oh   = free & (~free + 1'b1);
    hit       = |match;
    room      = |free;
    is_insert = (cur_op_q == bhs_pkg::ReqInsert);
    is_delete = (cur_op_q == bhs_pkg::ReqDelete);
    ins_oh    = (is_insert && !hit) ? free_oh : '0;
    del_oh    = is_delete ? hit_oh : '0;
    valid_new = (valid_eff | ins_oh) & ~del_oh;
  end

  // Result transaction
  always_comb begin
    rsp_o.found        = hit;
    rsp_o.refused_full = is_insert & ~hit & ~room;
    rsp_o.bucket_index = bhs_pkg::BucketOutW'(cur_bucket_q);
  end

endmodule

// ===== rtl/core/bucketed_hash_set_unit.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_set_unit: hash set of short keys in fixed-size buckets
// Path: a request passes the stage-one register, the command queue, the back
// end's evaluation state and the result queue before its result can be popped.
// The back end takes a new command only after it has read a bucket row and
// written it back, so it never works on two lookups at once.
// Reset: queues empty, all buckets empty at once (per-row flags, no sweep).
// ----------------------------------------------------------------------------
module bucketed_hash_set_unit #(
  parameter int unsigned Buckets  = bhs_pkg::BucketsDefault,
  parameter int unsigned KeyChars = bhs_pkg::KeyCharsDefault,
  parameter int unsigned Ways     = bhs_pkg::WaysDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  bhs_pkg::req_t req_i,
  output logic          full,
  input  logic          pop,
  output bhs_pkg::rsp_t rsp_o,
  output logic          empty
);

  localparam int unsigned CanonW = bhs_pkg::CharW * bhs_pkg::chars_used(KeyChars);
  localparam int unsigned BktW   = $clog2(Buckets);
  localparam int unsigned RspW   = $bits(bhs_pkg::rsp_t);

  logic               cmd_empty, cmd_pop;
  bhs_pkg::req_type_e cmd_op;
  logic [CanonW-1:0]  cmd_key;
  logic [BktW-1:0]    cmd_bucket;
  logic               rsp_full, rsp_push;
  bhs_pkg::rsp_t      rsp_new;
  logic [RspW-1:0]    rsp_rdata;

  // Intake, hash and command queue
  bhs_front #(
    .Buckets  (Buckets),
    .KeyChars (KeyChars)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (push),
    .req_i        (req_i),
    .req_full_o   (full),
    .cmd_pop_i    (cmd_pop),
    .cmd_empty_o  (cmd_empty),
    .cmd_op_o     (cmd_op),
    .cmd_key_o    (cmd_key),
    .cmd_bucket_o (cmd_bucket)
  );

  // Bucket lookup and update
  bhs_back #(
    .Buckets  (Buckets),
    .Ways     (Ways),
    .KeyChars (KeyChars)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .cmd_op_i     (cmd_op),
    .cmd_key_i    (cmd_key),
    .cmd_bucket_i (cmd_bucket),
    .rsp_full_i   (rsp_full),
    .rsp_push_o   (rsp_push),
    .rsp_o        (rsp_new)
  );

  // Result queue
  bhs_fifo #(
    .Width (RspW),
    .Depth (bhs_pkg::QueueDepth)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (rsp_new),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .rdata_o (rsp_rdata),
    .empty_o (empty)
  );

  assign rsp_o = bhs_pkg::rsp_t'(rsp_rdata);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bucketed_hash_set_unit
// A clocked driver sends insert, delete and query transactions from a backlog.
// A clocked monitor pops the results and checks each field against a
// behavioral copy of the set that runs in step with the accepted requests.
// Both sides idle at random, and the receiver holds off once long enough for
// the unit to fill up and raise full.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumBuckets = bhs_pkg::BucketsDefault;
  localparam int unsigned NumWays    = bhs_pkg::WaysDefault;
  localparam int unsigned NumChars   = bhs_pkg::KeyCharsDefault;
  localparam int unsigned NumSlots   = NumBuckets * NumWays;
  localparam int unsigned PoolSize   = 44;
  localparam int unsigned RandItems  = 650;
  localparam int unsigned HoldCycles = 200;
  // Request code outside the enum; the unit treats it as a query
  localparam logic [bhs_pkg::ReqTypeW-1:0] ReqSpare = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  bhs_pkg::req_t req_i = '0;
  logic full;
  logic empty;
  bhs_pkg::rsp_t rsp_o;

  // Behavioral copy of the set
  logic [bhs_pkg::KeyW-1:0] slot_key   [NumSlots];
  logic                     slot_taken [NumSlots];

  bhs_pkg::req_t            req_backlog[$];
  bhs_pkg::rsp_t            rsp_expected[$];
  logic [bhs_pkg::KeyW-1:0] key_pool[PoolSize];
  int unsigned reqs_total = 0;
  int unsigned reqs_sent  = 0;
  int unsigned rsps_seen  = 0;
  int unsigned rsps_due   = 0;
  int unsigned err_count  = 0;
  int unsigned send_wait  = 0;
  int unsigned recv_wait  = 0;
  logic        hold_rx    = 1'b0;

  bucketed_hash_set_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .req_i  (req_i),
    .full   (full),
    .pop    (pop),
    .rsp_o  (rsp_o),
    .empty  (empty)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the set and return the result it must produce
  function automatic bhs_pkg::rsp_t hash_set_apply(bhs_pkg::req_t rq);
    logic [bhs_pkg::KeyW-1:0] k;
    logic [bhs_pkg::CharW-1:0] ch;
    logic ended;
    int unsigned sum;
    int unsigned base;
    int hit;
    int spare;
    bhs_pkg::rsp_t r;
    k = '0;
    ended = 1'b0;
    sum = 0;
    hit = -1;
    spare = -1;
    // key ends at its first zero byte
    for (int i = 0; i < NumChars; i++) begin
      ch = rq.key[bhs_pkg::CharW*i +: bhs_pkg::CharW];
      if (ch == '0) ended = 1'b1;
      if (!ended) begin
        k[bhs_pkg::CharW*i +: bhs_pkg::CharW] = ch;
        sum += ch;
      end
    end
    base = (sum % NumBuckets) * NumWays;
    for (int w = 0; w < NumWays; w++) begin
      if (slot_taken[base+w]) begin
        if (hit < 0 && slot_key[base+w] == k) hit = base + w;
      end else if (spare < 0) begin
        spare = base + w;
      end
    end
    r.found        = (hit >= 0);
    r.refused_full = 1'b0;
    r.bucket_index = bhs_pkg::BucketOutW'(sum % NumBuckets);
    if (rq.req_type == bhs_pkg::ReqInsert) begin
      if (hit < 0) begin
        if (spare >= 0) begin
          slot_key[spare]   = k;
          slot_taken[spare] = 1'b1;
        end else begin
          r.refused_full = 1'b1;
        end
      end
    end else if (rq.req_type == bhs_pkg::ReqDelete) begin
      if (hit >= 0) slot_taken[hit] = 1'b0;
    end
    return r;
  endfunction

  // Idle cycles before the next transaction; one stretch in three runs flat out
  function automatic int unsigned pick_wait(int unsigned n);
    if ((n / 96) % 3 == 1) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
             $time, rsps_seen, what, got, want);
    err_count++;
  endtask

  task automatic queue_req(logic [bhs_pkg::ReqTypeW-1:0] op,
                           logic [bhs_pkg::KeyW-1:0] k);
    bhs_pkg::req_t rq;
    rq.req_type = op;
    rq.key      = k;
    req_backlog.push_back(rq);
    reqs_total++;
  endtask

  // Driver: offers the oldest pending request, holds it until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      logic taken;
      taken = push && !full;
      if (taken) begin
        rsp_expected.push_back(hash_set_apply(req_i));
        rsps_due++;
        void'(req_backlog.pop_front());
        reqs_sent++;
        send_wait = pick_wait(reqs_sent);
      end
      if (push && !taken) begin
        // keep offering the same transaction
      end else if (send_wait > 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        push  <= 1'b1;
        req_i <= req_backlog[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pops results and checks them against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      bhs_pkg::rsp_t want;
      if (pop && !empty) begin
        if (rsp_expected.size() == 0) begin
          $display("[%0t] result with no request outstanding", $time);
          err_count++;
        end else begin
          want = rsp_expected.pop_front();
          rsps_due--;
          if (rsp_o.found !== want.found) report("found", rsp_o.found, want.found);
          if (rsp_o.refused_full !== want.refused_full)
            report("refused_full", rsp_o.refused_full, want.refused_full);
          if (rsp_o.bucket_index !== want.bucket_index)
            report("bucket_index", rsp_o.bucket_index, want.bucket_index);
        end
        rsps_seen++;
        recv_wait = pick_wait(rsps_seen + 48);
      end
      if (hold_rx) begin
        pop <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so that the unit backs up into full
  initial begin
    wait (reqs_sent >= 150);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Time limit
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [63:0] raw;
    logic [bhs_pkg::KeyW-1:0] k;
    int unsigned len;
    int unsigned roll;
    logic [bhs_pkg::ReqTypeW-1:0] op;

    for (int s = 0; s < NumSlots; s++) begin
      slot_key[s]   = '0;
      slot_taken[s] = 1'b0;
    end

    // Directed: empty key, all-ones key, one bucket filled past its ways
    queue_req(bhs_pkg::ReqInsert, '0);
    queue_req(bhs_pkg::ReqQuery, 48'h1200_0000_0000);     // empty key with trailing junk
    queue_req(bhs_pkg::ReqInsert, '1);
    queue_req(ReqSpare, '1);
    for (int c = 1; c <= 7; c++) queue_req(bhs_pkg::ReqInsert, bhs_pkg::KeyW'(4 * c));
    queue_req(bhs_pkg::ReqInsert, 48'h20);                // bucket 0 is full now
    queue_req(bhs_pkg::ReqInsert, 48'h04);                // already present
    queue_req(bhs_pkg::ReqDelete, '0);                    // frees the first slot
    queue_req(bhs_pkg::ReqDelete, '0);                    // absent now
    queue_req(bhs_pkg::ReqInsert, 48'h20);
    queue_req(bhs_pkg::ReqQuery, 48'hA5A5_5A00_0004);     // junk after the terminator
    queue_req(bhs_pkg::ReqDelete, '1);
    queue_req(bhs_pkg::ReqDelete, 48'h7700_0000_0020);

    // Pool of well-formed keys, enough to overflow some buckets
    for (int p = 0; p < PoolSize; p++) begin
      k = '0;
      len = $urandom_range(1, NumChars);
      for (int i = 0; i < len; i++)
        k[bhs_pkg::CharW*i +: bhs_pkg::CharW] = bhs_pkg::CharW'($urandom_range(1, 255));
      key_pool[p] = k;
    end

    // Random: mostly pool keys, some aliased with junk, the rest noise
    for (int n = 0; n < RandItems; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        k = key_pool[$urandom_range(0, PoolSize - 1)];
        if ($urandom_range(0, 4) == 0) begin
          len = 0;
          while (len < NumChars && k[bhs_pkg::CharW*len +: bhs_pkg::CharW] != '0) len++;
          for (int i = len + 1; i < NumChars; i++)
            k[bhs_pkg::CharW*i +: bhs_pkg::CharW] = bhs_pkg::CharW'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) op = bhs_pkg::ReqInsert;
        else if (roll < 70) op = bhs_pkg::ReqDelete;
        else if (roll < 95) op = bhs_pkg::ReqQuery;
        else op = ReqSpare;
      end else begin
        raw = {$urandom, $urandom};
        k   = raw[bhs_pkg::KeyW-1:0];
        op  = bhs_pkg::ReqTypeW'($urandom_range(0, 3));
      end
      queue_req(op, k);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (reqs_sent == reqs_total);
    wait (rsps_due == 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== bucketed_hash_set_unit.f =====
rtl/core/bhs_pkg.sv
rtl/core/bhs_fifo.sv
rtl/core/bhs_front.sv
rtl/core/bhs_back.sv
rtl/core/bucketed_hash_set_unit.sv
tb/testbench.sv
